/* sv/tot_pkg.sv */
// Package for the two-opt tour improver.
// Holds the sizes, the item kind codes and the memory request types.
// Has no dependencies.
package tot_pkg;

	localparam int MAX_CITIES = 64;
	localparam int DIST_BITS  = 16;
	localparam int CITY_W     = 6;
	localparam int COUNT_W    = 7;
	localparam int COST_W     = 22;
	localparam int PASS_W     = 10;
	localparam int DADDR_W    = 2 * CITY_W;
	localparam int SUM_W      = DIST_BITS + 1;

	localparam logic [1:0] KIND_DIST = 2'd0;
	localparam logic [1:0] KIND_TOUR = 2'd1;
	localparam logic [1:0] KIND_RUN  = 2'd2;

	localparam logic [COUNT_W-1:0] COUNT_MIN   = COUNT_W'(3);
	localparam logic [COUNT_W-1:0] COUNT_TOP   = COUNT_W'(MAX_CITIES);
	localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(64);
	localparam logic [PASS_W-1:0]  PASS_LAST   = {PASS_W{1'b1}};

	typedef struct packed {
		logic              we;
		logic [CITY_W-1:0] waddr;
		logic [CITY_W-1:0] wdata;
		logic [CITY_W-1:0] raddr;
	} tot_tour_req_t;

	typedef struct packed {
		logic                 we;
		logic [DADDR_W-1:0]   waddr;
		logic [DIST_BITS-1:0] wdata;
		logic [DADDR_W-1:0]   raddr;
	} tot_dist_req_t;

endpackage

/* sv/tot_dist_mem.sv */
// Distance matrix memory: one write port and one registered read port.
// Depends on tot_pkg.
module tot_dist_mem (
	input  logic                           clk,
	input  tot_pkg::tot_dist_req_t         req,
	output logic [tot_pkg::DIST_BITS-1:0]  rdata
);
	import tot_pkg::*;

	logic [DIST_BITS-1:0] mem [MAX_CITIES*MAX_CITIES];

	// Write first in program order; the read returns the old word on a collision.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata <= mem[req.raddr];
	end

endmodule

/* sv/tot_tour_mem.sv */
// Tour memory: city at each tour position, one write and one registered read port.
// Depends on tot_pkg.
module tot_tour_mem (
	input  logic                        clk,
	input  tot_pkg::tot_tour_req_t      req,
	output logic [tot_pkg::CITY_W-1:0]  rdata
);
	import tot_pkg::*;

	logic [CITY_W-1:0] mem [MAX_CITIES];

	// Synchronous write and registered read.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata <= mem[req.raddr];
	end

endmodule

/* sv/tot_engine.sv */
// Sequencer of the tour improver: loads, 2-opt passes, cost sum and tour output.
// Depends on tot_pkg; drives the request ports of the two memories.
module tot_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [tot_pkg::COUNT_W-1:0]   city_count,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    kind,
	input  logic [tot_pkg::CITY_W-1:0]    from_city,
	input  logic [tot_pkg::CITY_W-1:0]    to_city,
	input  logic [tot_pkg::DIST_BITS-1:0] distance,
	input  logic [tot_pkg::CITY_W-1:0]    tour_position,
	input  logic [tot_pkg::CITY_W-1:0]    tour_city,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [tot_pkg::CITY_W-1:0]    city,
	output logic [tot_pkg::COST_W-1:0]    tour_cost,
	output logic                          last,
	output tot_pkg::tot_tour_req_t        tour_req,
	input  logic [tot_pkg::CITY_W-1:0]    tour_rd,
	output tot_pkg::tot_dist_req_t        dist_req,
	input  logic [tot_pkg::DIST_BITS-1:0] dist_rd
);
	import tot_pkg::*;

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_RT0  = 5'd1;
	localparam logic [4:0] ST_RT1  = 5'd2;
	localparam logic [4:0] ST_RT2  = 5'd3;
	localparam logic [4:0] ST_RT3  = 5'd4;
	localparam logic [4:0] ST_RD0  = 5'd5;
	localparam logic [4:0] ST_RD1  = 5'd6;
	localparam logic [4:0] ST_RD2  = 5'd7;
	localparam logic [4:0] ST_RD3  = 5'd8;
	localparam logic [4:0] ST_RD4  = 5'd9;
	localparam logic [4:0] ST_CMP  = 5'd10;
	localparam logic [4:0] ST_RV0  = 5'd11;
	localparam logic [4:0] ST_RV1  = 5'd12;
	localparam logic [4:0] ST_RV2  = 5'd13;
	localparam logic [4:0] ST_RV3  = 5'd14;
	localparam logic [4:0] ST_NEXT = 5'd15;
	localparam logic [4:0] ST_CS0  = 5'd16;
	localparam logic [4:0] ST_CS1  = 5'd17;
	localparam logic [4:0] ST_CS2  = 5'd18;
	localparam logic [4:0] ST_CS3  = 5'd19;
	localparam logic [4:0] ST_EM0  = 5'd20;
	localparam logic [4:0] ST_EM1  = 5'd21;
	localparam logic [4:0] ST_EM2  = 5'd22;

	logic [4:0]           state_q;
	logic [COUNT_W-1:0]   n_q;
	logic [CITY_W-1:0]    i_q, j_q, lo_q, hi_q, k_q;
	logic [CITY_W-1:0]    p_q, a_q, b_q, q_q, x_q, u_q;
	logic [SUM_W-1:0]     bef_q, aft_q;
	logic                 chg_q;
	logic [PASS_W-1:0]    pass_q;
	logic [COST_W-1:0]    cost_q;
	logic                 out_valid_q, last_q;
	logic [CITY_W-1:0]    city_q;
	logic [COST_W-1:0]    out_cost_q;

	logic                 accept;
	logic [COUNT_W-1:0]   n_sat;
	logic [COUNT_W-1:0]   j_inc, i_inc2, k_inc;
	logic [CITY_W-1:0]    j_wrap, k_wrap;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign city      = city_q;
	assign tour_cost = out_cost_q;
	assign last      = last_q;

	// Saturated count and wraparound neighbors.
	always_comb begin
		n_sat = city_count;
		if (city_count < COUNT_MIN) begin
			n_sat = COUNT_MIN;
		end else if (city_count > COUNT_TOP) begin
			n_sat = COUNT_TOP;
		end
		j_inc  = {1'b0, j_q} + COUNT_W'(1);
		i_inc2 = {1'b0, i_q} + COUNT_W'(2);
		k_inc  = {1'b0, k_q} + COUNT_W'(1);
		j_wrap = (j_inc == n_q) ? '0 : j_inc[CITY_W-1:0];
		k_wrap = (k_inc == n_q) ? '0 : k_inc[CITY_W-1:0];
	end

	// Memory requests for each step of the sequencer.
	always_comb begin
		tour_req       = '0;
		dist_req       = '0;
		dist_req.waddr = {from_city, to_city};
		dist_req.wdata = distance;
		case (state_q)
			ST_IDLE: begin
				dist_req.we    = accept && (kind == KIND_DIST);
				tour_req.we    = accept && (kind == KIND_TOUR);
				tour_req.waddr = tour_position;
				tour_req.wdata = tour_city;
			end
			ST_RT0:  tour_req.raddr = i_q - CITY_W'(1);
			ST_RT1:  tour_req.raddr = i_q;
			ST_RT2:  tour_req.raddr = j_q;
			ST_RT3:  tour_req.raddr = j_wrap;
			ST_RD0:  dist_req.raddr = {p_q, a_q};
			ST_RD1:  dist_req.raddr = {b_q, q_q};
			ST_RD2:  dist_req.raddr = {p_q, b_q};
			ST_RD3:  dist_req.raddr = {a_q, q_q};
			ST_RV0:  tour_req.raddr = lo_q;
			ST_RV1:  tour_req.raddr = hi_q;
			ST_RV2: begin
				tour_req.we    = 1'b1;
				tour_req.waddr = lo_q;
				tour_req.wdata = tour_rd;
			end
			ST_RV3: begin
				tour_req.we    = 1'b1;
				tour_req.waddr = hi_q;
				tour_req.wdata = x_q;
			end
			ST_CS0:  tour_req.raddr = k_q;
			ST_CS1:  tour_req.raddr = k_wrap;
			ST_CS2:  dist_req.raddr = {u_q, tour_rd};
			ST_EM0:  tour_req.raddr = k_q;
			default: tour_req = '0;
		endcase
	end

	// Sequencer state and working registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			chg_q       <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && (kind == KIND_RUN)) begin
						n_q     <= n_sat;
						i_q     <= CITY_W'(1);
						j_q     <= CITY_W'(2);
						chg_q   <= 1'b0;
						pass_q  <= '0;
						state_q <= ST_RT0;
					end
				end
				ST_RT0: state_q <= ST_RT1;
				// Each tour read returns in the cycle after its address.
				ST_RT1: begin
					p_q     <= tour_rd;
					state_q <= ST_RT2;
				end
				ST_RT2: begin
					a_q     <= tour_rd;
					state_q <= ST_RT3;
				end
				ST_RT3: begin
					b_q     <= tour_rd;
					state_q <= ST_RD0;
				end
				ST_RD0: begin
					q_q     <= tour_rd;
					state_q <= ST_RD1;
				end
				ST_RD1: begin
					bef_q   <= {1'b0, dist_rd};
					state_q <= ST_RD2;
				end
				ST_RD2: begin
					bef_q   <= bef_q + {1'b0, dist_rd};
					state_q <= ST_RD3;
				end
				ST_RD3: begin
					aft_q   <= {1'b0, dist_rd};
					state_q <= ST_RD4;
				end
				ST_RD4: begin
					aft_q   <= aft_q + {1'b0, dist_rd};
					state_q <= ST_CMP;
				end
				// Strict gain starts an in-place reversal of positions i..j.
				ST_CMP: begin
					if (aft_q < bef_q) begin
						chg_q   <= 1'b1;
						lo_q    <= i_q;
						hi_q    <= j_q;
						state_q <= ST_RV0;
					end else begin
						state_q <= ST_NEXT;
					end
				end
				ST_RV0: state_q <= (hi_q > lo_q) ? ST_RV1 : ST_NEXT;
				ST_RV1: begin
					x_q     <= tour_rd;
					state_q <= ST_RV2;
				end
				ST_RV2: state_q <= ST_RV3;
				ST_RV3: begin
					lo_q    <= lo_q + CITY_W'(1);
					hi_q    <= hi_q - CITY_W'(1);
					state_q <= ST_RV0;
				end
				// Step to the next pair, the next pass, or the cost sum.
				ST_NEXT: begin
					if (j_inc < n_q) begin
						j_q     <= j_inc[CITY_W-1:0];
						state_q <= ST_RT0;
					end else if (i_inc2 < n_q) begin
						i_q     <= i_q + CITY_W'(1);
						j_q     <= i_inc2[CITY_W-1:0];
						state_q <= ST_RT0;
					end else if (chg_q && (pass_q != PASS_LAST)) begin
						pass_q  <= pass_q + PASS_W'(1);
						i_q     <= CITY_W'(1);
						j_q     <= CITY_W'(2);
						chg_q   <= 1'b0;
						state_q <= ST_RT0;
					end else begin
						k_q     <= '0;
						cost_q  <= '0;
						state_q <= ST_CS0;
					end
				end
				ST_CS0: state_q <= ST_CS1;
				ST_CS1: begin
					u_q     <= tour_rd;
					state_q <= ST_CS2;
				end
				ST_CS2: state_q <= ST_CS3;
				ST_CS3: begin
					cost_q <= cost_q + COST_W'(dist_rd);
					if (k_inc == n_q) begin
						k_q     <= '0;
						state_q <= ST_EM0;
					end else begin
						k_q     <= k_inc[CITY_W-1:0];
						state_q <= ST_CS0;
					end
				end
				ST_EM0: state_q <= ST_EM1;
				// Present one city; the cost rides on the final one.
				ST_EM1: begin
					out_valid_q <= 1'b1;
					city_q      <= tour_rd;
					last_q      <= (k_inc == n_q);
					out_cost_q  <= (k_inc == n_q) ? cost_q : '0;
					state_q     <= ST_EM2;
				end
				ST_EM2: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						if (last_q) begin
							state_q <= ST_IDLE;
						end else begin
							k_q     <= k_inc[CITY_W-1:0];
							state_q <= ST_EM0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* sv/two_opt_tour_improver_unit.sv */
// Two-opt tour improver top level: configuration register, memories and sequencer.
// Depends on tot_pkg, tot_dist_mem, tot_tour_mem and tot_engine.
//
// Load requests (distance entry or tour position) can arrive back to back.
// A run request holds the input stalled until the whole improved tour has
// been delivered: each position pair of a pass takes memory reads, a compare
// and the step to the next pair, a taken pair adds a reversal that swaps the
// tour positions pairwise from both ends, and a pass covers (n-1)(n-2)/2
// pairs. Passes repeat until one makes no change (at most 1024). The cost sum
// then reads each city and its successor, and output presents one city at a
// time and holds while out_stall is high. The sequencing is set by the single
// read port of the tour memory and of the distance memory.
module two_opt_tour_improver_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tot_pkg::COUNT_W-1:0]   cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    kind,
	input  logic [tot_pkg::CITY_W-1:0]    from_city,
	input  logic [tot_pkg::CITY_W-1:0]    to_city,
	input  logic [tot_pkg::DIST_BITS-1:0] distance,
	input  logic [tot_pkg::CITY_W-1:0]    tour_position,
	input  logic [tot_pkg::CITY_W-1:0]    tour_city,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [tot_pkg::CITY_W-1:0]    city,
	output logic [tot_pkg::COST_W-1:0]    tour_cost,
	output logic                          last
);
	import tot_pkg::*;

	logic [COUNT_W-1:0]   city_count_q;
	tot_tour_req_t        tour_req;
	tot_dist_req_t        dist_req;
	logic [CITY_W-1:0]    tour_rd;
	logic [DIST_BITS-1:0] dist_rd;

	assign cfg_ready = 1'b1;

	// City count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			city_count_q <= COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			city_count_q <= cfg_data;
		end
	end

	tot_dist_mem u_dist_mem (
		.clk   (clk),
		.req   (dist_req),
		.rdata (dist_rd)
	);

	tot_tour_mem u_tour_mem (
		.clk   (clk),
		.req   (tour_req),
		.rdata (tour_rd)
	);

	tot_engine u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.city_count    (city_count_q),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.kind          (kind),
		.from_city     (from_city),
		.to_city       (to_city),
		.distance      (distance),
		.tour_position (tour_position),
		.tour_city     (tour_city),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.city          (city),
		.tour_cost     (tour_cost),
		.last          (last),
		.tour_req      (tour_req),
		.tour_rd       (tour_rd),
		.dist_req      (dist_req),
		.dist_rd       (dist_rd)
	);

endmodule

/* sv/tot_checker.sv */
// Port-level checks for the two-opt tour improver, bound to the top level.
// Depends on tot_pkg and two_opt_tour_improver_unit.
module tot_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic [1:0]                    kind,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [tot_pkg::CITY_W-1:0]    city,
	input logic [tot_pkg::COST_W-1:0]    tour_cost,
	input logic                          last
);
	import tot_pkg::*;

	// A run request, once accepted, leaves the input stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && kind == KIND_RUN) |=> in_stall)
		else $error("run request did not block the input");

	// Results appear only while a run is in progress.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("result shown while input is open");

	// Only the final city carries a cost.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |-> (tour_cost == '0))
		else $error("cost on a city other than the last");

	// A stalled result holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(city) && $stable(last)))
		else $error("stalled result changed");

endmodule

bind two_opt_tour_improver_unit tot_checker u_tot_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.kind      (kind),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.city      (city),
	.tour_cost (tour_cost),
	.last      (last)
);
